/* src/assert_macros.svh */
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

/* src/dpf_pkg.sv */
`timescale 1ns / 1ps
package dpf_pkg;

  localparam int unsigned LIMIT_DEF      = 65536;
  localparam int unsigned MAX_PRIMES_DEF = 6542;
  localparam int unsigned VALUE_W        = 16;

  typedef struct packed {
    logic clr_step;
    logic store;
    logic mark_init;
    logic mark_step;
    logic n_inc;
    logic load;
    logic sq_load;
    logic div_start;
    logic div_step;
    logic quo_take;
    logic k_next;
    logic push_p;
    logic push_v;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic composite;
    logic dbl_over;
    logic mark_last;
    logic sieve_end;
    logic k_end;
    logic sq_gt;
    logic div_done;
    logic rem_zero;
    logic hit;
    logic tail_ok;
    logic push_ok;
    logic out_free;
  } stat_t;

endpackage

/* src/distinct_prime_factorizer_top.sv */
`timescale 1ns / 1ps
// distinct prime factorizer
// input stream: one 16-bit value per transfer on s_axis_tdata.
// output stream: one transfer per distinct prime factor of the value, in ascending
// order; m_axis_tlast marks the final one. values 0 and 1, or values with no prime in
// the table, give a single transfer with prime 0 and m_axis_tuser (no factor) set.
// after reset the composite bit map (LIMIT entries) is cleared one entry a cycle,
// then the prime table is built by a sieve over the candidates from 2 below LIMIT,
// ending early once the table is full; multiples of each prime are crossed out one
// per cycle. s_axis_tready stays low until the table is done.
// per value the trial divider walks table primes up to the square root of the
// remaining cofactor; each prime is tried by the one-bit-per-cycle remainder unit,
// and a prime that divides is divided out again until a remainder is left.
// one value is in work at a time; the next is taken after the final result is
// loaded into the output register. a stalled receiver holds the output register and
// the factor search waits until it is free.
module distinct_prime_factorizer_top #(
  parameter int unsigned LIMIT      = dpf_pkg::LIMIT_DEF,
  parameter int unsigned MAX_PRIMES = dpf_pkg::MAX_PRIMES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [dpf_pkg::VALUE_W-1:0] s_axis_tdata,  // [15:0] value
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [dpf_pkg::VALUE_W-1:0] m_axis_tdata,  // [15:0] prime_factor
  output logic                        m_axis_tuser,  // [0] no_factor
  output logic                        m_axis_tlast
);

  dpf_pkg::cmd_t  cmd;
  dpf_pkg::stat_t stat;

  dpf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dpf_dpath #(
    .LIMIT      (LIMIT),
    .MAX_PRIMES (MAX_PRIMES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_value_i  (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_prime_o (m_axis_tdata),
    .out_none_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

/* src/dpf_ctrl.sv */
`timescale 1ns / 1ps
module dpf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  dpf_pkg::stat_t stat_i,
  output dpf_pkg::cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_RD,
    S_TEST,
    S_MARK,
    S_ADV,
    S_IDLE,
    S_FETCH,
    S_SQ,
    S_CMP,
    S_DSTART,
    S_DIV,
    S_DCHK,
    S_TAIL,
    S_FIN
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_done) state_d = S_RD;
      end
      S_RD: begin
        state_d = S_TEST;
      end
      S_TEST: begin
        if (stat_i.composite) begin
          state_d = S_ADV;
        end else begin
          cmd_o.store = 1'b1;
          if (stat_i.dbl_over) begin
            state_d = S_ADV;
          end else begin
            cmd_o.mark_init = 1'b1;
            state_d         = S_MARK;
          end
        end
      end
      S_MARK: begin
        cmd_o.mark_step = 1'b1;
        if (stat_i.mark_last) state_d = S_ADV;
      end
      S_ADV: begin
        if (stat_i.sieve_end) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.n_inc = 1'b1;
          state_d     = S_RD;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_FETCH;
        end
      end
      S_FETCH: begin
        state_d = stat_i.k_end ? S_FIN : S_SQ;
      end
      S_SQ: begin
        cmd_o.sq_load = 1'b1;
        state_d       = S_CMP;
      end
      S_CMP: begin
        state_d = stat_i.sq_gt ? S_TAIL : S_DSTART;
      end
      S_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          state_d = S_DCHK;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_DCHK: begin
        if (!stat_i.rem_zero) begin
          cmd_o.k_next = 1'b1;
          state_d      = S_FETCH;
        end else if (stat_i.hit) begin
          cmd_o.quo_take = 1'b1;
          state_d        = S_DSTART;
        end else if (stat_i.push_ok) begin
          cmd_o.push_p   = 1'b1;
          cmd_o.quo_take = 1'b1;
          state_d        = S_DSTART;
        end
      end
      S_TAIL: begin
        if (!stat_i.tail_ok) begin
          state_d = S_FIN;
        end else if (stat_i.push_ok) begin
          cmd_o.push_v = 1'b1;
          state_d      = S_FIN;
        end
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* src/dpf_dpath.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dpf_dpath #(
  parameter int unsigned LIMIT      = dpf_pkg::LIMIT_DEF,
  parameter int unsigned MAX_PRIMES = dpf_pkg::MAX_PRIMES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dpf_pkg::cmd_t               cmd_i,
  output dpf_pkg::stat_t              stat_o,
  input  logic [dpf_pkg::VALUE_W-1:0] in_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [dpf_pkg::VALUE_W-1:0] out_prime_o,
  output logic                        out_none_o,
  output logic                        out_last_o
);

  localparam int unsigned AW = $clog2(LIMIT);
  localparam int unsigned CW = $clog2(MAX_PRIMES + 1);
  localparam int unsigned KW = $clog2(MAX_PRIMES);
  localparam int unsigned VW = dpf_pkg::VALUE_W;
  localparam int unsigned XW = (AW > VW) ? AW : VW;
  localparam int unsigned SW = (2 * AW > VW) ? 2 * AW : VW;
  localparam int unsigned DW = $clog2(VW + 1);

  // sieve memories
  logic          comp_map [LIMIT];
  logic [AW-1:0] ptab     [MAX_PRIMES];
  logic          map_rd_q;
  logic [AW-1:0] ptab_rd_q;

  logic [AW-1:0] n_q, m_q, last_q;
  logic [CW-1:0] cnt_q, k_q;
  logic [AW:0]   dbl_sum, mark_sum;

  // factoring datapath
  logic [VW-1:0]   v_q;
  logic [AW-1:0]   p_q;
  logic [2*AW-1:0] sq_q, p_ext;
  logic [VW-1:0]   dvd_q;
  logic [AW-1:0]   rem_q;
  logic [DW-1:0]   step_q;
  logic [AW:0]     rem_sh, rem_sub;
  logic            qbit;
  logic            hit_q;

  logic            pend_valid_q;
  logic [VW-1:0]   pend_prime_q;
  logic [VW-1:0]   push_val;
  logic            push;
  logic            out_free;

  assign dbl_sum  = {1'b0, n_q} + {1'b0, n_q};
  assign mark_sum = {1'b0, m_q} + {1'b0, n_q};
  assign p_ext    = (2 * AW)'(ptab_rd_q);
  assign rem_sh   = {rem_q, dvd_q[VW-1]};
  assign rem_sub  = rem_sh - {1'b0, p_q};
  assign qbit     = (rem_sh >= {1'b0, p_q});
  assign push     = cmd_i.push_p | cmd_i.push_v;
  assign push_val = cmd_i.push_v ? v_q : VW'(p_q);
  assign out_free = !out_valid_o || out_ready_i;

  always_comb begin
    stat_o.clr_done  = (m_q == AW'(LIMIT - 1));
    stat_o.composite = map_rd_q;
    stat_o.dbl_over  = (dbl_sum >= (AW + 1)'(LIMIT));
    stat_o.mark_last = (mark_sum >= (AW + 1)'(LIMIT));
    stat_o.sieve_end = (n_q == AW'(LIMIT - 1)) || (cnt_q == CW'(MAX_PRIMES));
    stat_o.k_end     = (k_q == cnt_q);
    stat_o.sq_gt     = (SW'(sq_q) > SW'(v_q));
    stat_o.div_done  = (step_q == '0);
    stat_o.rem_zero  = (rem_q == '0);
    stat_o.hit       = hit_q;
    stat_o.tail_ok   = (v_q >= VW'(2)) && (XW'(v_q) <= XW'(last_q));
    stat_o.push_ok   = !pend_valid_q || out_free;
    stat_o.out_free  = out_free;
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step || cmd_i.mark_step) begin
      comp_map[m_q] <= cmd_i.mark_step;
    end
    map_rd_q <= comp_map[n_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      ptab[cnt_q[KW-1:0]] <= n_q;
    end
    ptab_rd_q <= ptab[k_q[KW-1:0]];
  end

  // control counters and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q          <= '0;
      n_q          <= AW'(2);
      cnt_q        <= '0;
      k_q          <= '0;
      step_q       <= '0;
      hit_q        <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_o  <= 1'b0;
    end else begin
      if (cmd_i.clr_step) begin
        m_q <= m_q + AW'(1);
      end else if (cmd_i.mark_init) begin
        m_q <= dbl_sum[AW-1:0];
      end else if (cmd_i.mark_step) begin
        m_q <= mark_sum[AW-1:0];
      end
      if (cmd_i.n_inc) n_q <= n_q + AW'(1);
      if (cmd_i.store) cnt_q <= cnt_q + CW'(1);

      if (cmd_i.load) begin
        k_q <= '0;
      end else if (cmd_i.k_next) begin
        k_q <= k_q + CW'(1);
      end

      if (cmd_i.div_start) begin
        step_q <= DW'(VW);
      end else if (cmd_i.div_step) begin
        step_q <= step_q - DW'(1);
      end

      if (cmd_i.load || cmd_i.k_next) begin
        hit_q <= 1'b0;
      end else if (cmd_i.push_p) begin
        hit_q <= 1'b1;
      end

      if (cmd_i.flush) begin
        out_valid_o  <= 1'b1;
        pend_valid_q <= 1'b0;
      end else begin
        if (push && pend_valid_q) begin
          out_valid_o <= 1'b1;
        end else if (out_valid_o && out_ready_i) begin
          out_valid_o <= 1'b0;
        end
        if (push) pend_valid_q <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) last_q <= n_q;
    if (cmd_i.load) begin
      v_q <= in_value_i;
    end else if (cmd_i.quo_take) begin
      v_q <= dvd_q;
    end
    if (cmd_i.sq_load) begin
      p_q  <= ptab_rd_q;
      sq_q <= p_ext * p_ext;
    end
    if (cmd_i.div_start) begin
      dvd_q <= v_q;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[VW-2:0], qbit};
      rem_q <= qbit ? rem_sub[AW-1:0] : rem_sh[AW-1:0];
    end
    if (push) pend_prime_q <= push_val;
    if (cmd_i.flush) begin
      out_prime_o <= pend_valid_q ? pend_prime_q : '0;
      out_none_o  <= !pend_valid_q;
      out_last_o  <= 1'b1;
    end else if (push && pend_valid_q) begin
      out_prime_o <= pend_prime_q;
      out_none_o  <= 1'b0;
      out_last_o  <= 1'b0;
    end
  end

  `ASSERT_AT(a_store_room, clk_i, rst_ni, cmd_i.store |-> (cnt_q < CW'(MAX_PRIMES)), "prime stored into a full table")
  `ASSERT_AT(a_push_room, clk_i, rst_ni, (push && pend_valid_q) |-> out_free, "result pushed over a waiting transfer")
  `ASSERT_AT(a_flush_room, clk_i, rst_ni, cmd_i.flush |-> out_free, "final result over a waiting transfer")
  `ASSERT_AT(a_div_prime, clk_i, rst_ni, cmd_i.div_start |-> (p_q >= AW'(2)), "division by a non-prime divisor")
  `ASSERT_NEVER(a_quo_exact, clk_i, rst_ni, cmd_i.quo_take && (rem_q != '0), "quotient taken with a remainder left")

endmodule

/* tb/distinct_prime_factorizer_top_tb.sv */
`timescale 1ns / 1ps
module distinct_prime_factorizer_top_tb;

  localparam int unsigned VALUE_W     = dpf_pkg::VALUE_W;
  localparam int unsigned SIEVE_LIMIT = dpf_pkg::LIMIT_DEF;
  localparam int unsigned TABLE_DEPTH = dpf_pkg::MAX_PRIMES_DEF;
  localparam int unsigned MAX_FACTORS = 6;
  localparam int unsigned RANDOM_PER_PHASE = 27;
  localparam int unsigned DIRECTED_ROWS = 18;
  localparam int unsigned SETTLE_CYCLES = 2000;

  typedef struct packed {
    logic [VALUE_W-1:0] prime;
    logic               no_factor;
    logic               last_factor;
  } factor_t;

  // typed rows carry their expected primes, the others go to the predictor
  typedef struct packed {
    logic [VALUE_W-1:0]           value;
    logic                         typed;
    logic                         no_factor;
    logic [2:0]                   count;
    logic [0:5][VALUE_W-1:0]      primes;
  } stim_row_t;

  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{16'd0,     1'b1, 1'b1, 3'd0, '0},
    '{16'd1,     1'b1, 1'b1, 3'd0, '0},
    '{16'd2,     1'b1, 1'b0, 3'd1, '{16'd2, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}},
    '{16'd3,     1'b0, 1'b0, 3'd0, '0},
    '{16'd4,     1'b1, 1'b0, 3'd1, '{16'd2, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}},
    '{16'd49,    1'b1, 1'b0, 3'd1, '{16'd7, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}},
    '{16'd30030, 1'b1, 1'b0, 3'd6, '{16'd2, 16'd3, 16'd5, 16'd7, 16'd11, 16'd13}},
    '{16'd32768, 1'b1, 1'b0, 3'd1, '{16'd2, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}},
    '{16'd32749, 1'b0, 1'b0, 3'd0, '0},
    '{16'd65521, 1'b1, 1'b0, 3'd1, '{16'd65521, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}},
    '{16'd65534, 1'b0, 1'b0, 3'd0, '0},
    '{16'd65535, 1'b1, 1'b0, 3'd4, '{16'd3, 16'd5, 16'd17, 16'd257, 16'd0, 16'd0}},
    '{16'd65025, 1'b1, 1'b0, 3'd3, '{16'd3, 16'd5, 16'd17, 16'd0, 16'd0, 16'd0}},
    '{16'd43690, 1'b0, 1'b0, 3'd0, '0},
    '{16'd21845, 1'b0, 1'b0, 3'd0, '0},
    '{16'd39270, 1'b0, 1'b0, 3'd0, '0},
    '{16'd15015, 1'b0, 1'b0, 3'd0, '0},
    '{16'd64507, 1'b0, 1'b0, 3'd0, '0}
  };

  localparam int unsigned SMALL_PRIMES [12] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [VALUE_W-1:0] s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [VALUE_W-1:0] m_axis_tdata;
  logic               m_axis_tuser;
  logic               m_axis_tlast;

  bit                 crossed_out [SIEVE_LIMIT];
  logic [VALUE_W-1:0] prime_list [TABLE_DEPTH];
  int unsigned        prime_total = 0;

  factor_t            expected_factors [$];
  factor_t            oldest_factor;
  int unsigned        fail_count = 0;
  int unsigned        send_idle_pct = 27;
  int unsigned        recv_idle_pct = 58;

  distinct_prime_factorizer_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #40ms;
    $display("FAIL");
    $finish;
  end

  // linear sieve, each composite crossed out by its smallest prime
  function automatic void build_prime_list();
    int unsigned n;
    int unsigned k;
    int unsigned m;
    prime_total = 0;
    for (n = 2; n < SIEVE_LIMIT; n++) begin
      if (!crossed_out[n] && prime_total < TABLE_DEPTH) begin
        prime_list[prime_total] = VALUE_W'(n);
        prime_total++;
      end
      for (k = 0; k < prime_total; k++) begin
        m = n * prime_list[k];
        if (m >= SIEVE_LIMIT) break;
        crossed_out[m] = 1'b1;
        if (n % prime_list[k] == 0) break;
      end
    end
  endfunction

  function automatic void queue_factor(input factor_t f);
    expected_factors.insert(expected_factors.size(), f);
  endfunction

  function automatic void predict_factors(input logic [VALUE_W-1:0] value);
    int unsigned rest;
    int unsigned k;
    int unsigned p;
    int unsigned found;
    factor_t     f;
    rest  = value;
    found = 0;
    for (k = 0; k < prime_total; k++) begin
      p = prime_list[k];
      if (p < 2 || p > rest) break;
      if (rest % p == 0) begin
        if (found < MAX_FACTORS) begin
          f.prime       = VALUE_W'(p);
          f.no_factor   = 1'b0;
          f.last_factor = 1'b0;
          queue_factor(f);
          found++;
        end
        while (rest % p == 0) rest = rest / p;
      end
    end
    if (found == 0) begin
      f.prime       = '0;
      f.no_factor   = 1'b1;
      f.last_factor = 1'b1;
      queue_factor(f);
    end else begin
      f = expected_factors.pop_back();
      f.last_factor = 1'b1;
      queue_factor(f);
    end
  endfunction

  function automatic logic [VALUE_W-1:0] next_random_value();
    int unsigned v;
    int unsigned p;
    v = 1;
    case ($urandom_range(3))
      0: v = $urandom_range(65535);
      1: v = $urandom_range(63);
      2: begin
        repeat ($urandom_range(1, 10)) begin
          p = SMALL_PRIMES[$urandom_range(11)];
          if (v * p <= 65535) v = v * p;
        end
      end
      default: begin
        p = prime_list[$urandom_range(prime_total - 1)];
        v = p * $urandom_range(1, 65535 / p);
      end
    endcase
    return VALUE_W'(v);
  endfunction

  task automatic send_value(input logic [VALUE_W-1:0] value);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_factors.size() == 0) begin
        $error("unexpected transfer: prime_factor %0d no_factor %0b last_factor %0b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        fail_count++;
      end else begin
        oldest_factor = expected_factors.pop_front();
        if (m_axis_tdata !== oldest_factor.prime) begin
          $error("prime_factor: expected %0d, got %0d", oldest_factor.prime, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tuser !== oldest_factor.no_factor) begin
          $error("no_factor: expected %0b, got %0b", oldest_factor.no_factor, m_axis_tuser);
          fail_count++;
        end
        if (m_axis_tlast !== oldest_factor.last_factor) begin
          $error("last_factor: expected %0b, got %0b", oldest_factor.last_factor,
                 m_axis_tlast);
          fail_count++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    int unsigned i;
    int unsigned k;
    int unsigned phase;
    stim_row_t   row;
    factor_t     f;
    build_prime_list();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (i = 0; i < DIRECTED_ROWS; i++) begin
      row = DIRECTED[i];
      send_value(row.value);
      if (!row.typed) begin
        predict_factors(row.value);
      end else if (row.no_factor) begin
        f.prime       = '0;
        f.no_factor   = 1'b1;
        f.last_factor = 1'b1;
        queue_factor(f);
      end else begin
        for (k = 0; k < row.count; k++) begin
          f.prime       = row.primes[k];
          f.no_factor   = 1'b0;
          f.last_factor = (k == row.count - 1);
          queue_factor(f);
        end
      end
    end

    for (phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 58;
        recv_idle_pct = 27;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (i = 0; i < RANDOM_PER_PHASE; i++) begin
        row.value = next_random_value();
        send_value(row.value);
        predict_factors(row.value);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (expected_factors.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* distinct_prime_factorizer_top.f */
+incdir+src
src/dpf_pkg.sv
src/dpf_ctrl.sv
src/dpf_dpath.sv
src/distinct_prime_factorizer_top.sv
tb/distinct_prime_factorizer_top_tb.sv
